[rtl/catmull_rom_curve_sampler_assert.svh]
// Assertion macros shared by the curve sampler RTL.
`ifndef CATMULL_ROM_CURVE_SAMPLER_ASSERT_SVH
`define CATMULL_ROM_CURVE_SAMPLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CRS_ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("curve sampler check failed");
`define CRS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("curve sampler check failed");
`else
`define CRS_ASSERT_IMPLY(lbl, clk, rst_n, pre, post)
`define CRS_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

[rtl/crs_pkg.sv]
// Shared constants, command types and blending weights of the curve sampler.
package crs_pkg;

    localparam int SAMPLES_PER_SEGMENT = 20;
    localparam int COORD_BITS          = 16;
    localparam int OUT_BITS            = 21;
    localparam int FRAC_BITS           = 4;
    localparam int TAPS                = 4;

    typedef struct packed {
        logic issue;
        logic seg_b;
        logic full_left;
        logic run_last;
        logic route_done;
        logic load;
        logic update;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic adv;
    } t_dp_status;

    function automatic longint crs_weight(input int k, input int tap, input int s);
        longint kk;
        longint ss;
        longint k2;
        longint k3;
        longint w;
        kk = k;
        ss = s;
        k2 = kk * kk;
        k3 = k2 * kk;
        case (tap)
            0: w = -k3 + 2 * k2 * ss - kk * ss * ss;
            1: w = 3 * k3 - 5 * k2 * ss + 2 * ss * ss * ss;
            2: w = -3 * k3 + 4 * k2 * ss + kk * ss * ss;
            default: w = k3 - k2 * ss;
        endcase
        return w;
    endfunction

endpackage

[rtl/crs_div_pipe.sv]
// Rounding-divide stage: division by a constant through a reciprocal multiply.
module crs_div_pipe #(
    parameter int DIVISOR  = 2 * crs_pkg::SAMPLES_PER_SEGMENT * crs_pkg::SAMPLES_PER_SEGMENT
                             * crs_pkg::SAMPLES_PER_SEGMENT,
    parameter int QUO_BITS = crs_pkg::OUT_BITS,
    parameter int REM_BITS = $clog2(DIVISOR) + QUO_BITS
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [REM_BITS-1:0] i_rem,
    input  logic                i_neg,
    input  logic                i_ovf,
    output logic [QUO_BITS-1:0] o_quo,
    output logic                o_neg,
    output logic                o_ovf
);

    function automatic int low_zeros(input int v);
        int n;
        n = 0;
        for (int i = 30; i >= 0; i--) begin
            if (v[i]) begin
                n = i;
            end
        end
        return n;
    endfunction

    localparam int     TZ      = low_zeros(DIVISOR);
    localparam int     ODD     = DIVISOR >> TZ;
    localparam int     XW      = REM_BITS - TZ;
    localparam int     RL      = XW + $clog2(ODD);
    localparam int     MW      = XW + 1;
    localparam int     PRW     = XW + MW;
    localparam longint RECIP_L = ((longint'(1) << RL) + longint'(ODD) - 1) / longint'(ODD);

    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    logic [XW-1:0]  dividend;
    logic [PRW-1:0] r_prod;
    logic           r_neg;
    logic           r_ovf;

    assign dividend = XW'(i_rem >> TZ);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PRW'(dividend) * PRW'(RECIP);
            r_neg  <= i_neg;
            r_ovf  <= i_ovf;
        end
    end

    assign o_quo = r_prod[RL +: QUO_BITS];
    assign o_neg = r_neg;
    assign o_ovf = r_ovf;

endmodule

[rtl/crs_datapath.sv]
// Point window, blending pipeline, rounding divide and output register.
module crs_datapath #(
    parameter int SAMPLES_PER_SEGMENT = crs_pkg::SAMPLES_PER_SEGMENT,
    parameter int COORD_BITS          = crs_pkg::COORD_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic signed [COORD_BITS-1:0]           i_point_x,
    input  logic signed [COORD_BITS-1:0]           i_point_y,
    input  crs_pkg::t_dp_cmd                       i_cmd,
    input  logic [$clog2(SAMPLES_PER_SEGMENT)-1:0] i_k,
    output crs_pkg::t_dp_status                    o_status,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [crs_pkg::OUT_BITS-1:0]    o_sample_x,
    output logic signed [crs_pkg::OUT_BITS-1:0]    o_sample_y,
    output logic                                   o_run_last,
    output logic                                   o_route_done
);

    localparam int S    = SAMPLES_PER_SEGMENT;
    localparam int CB   = COORD_BITS;
    localparam int TAPS = crs_pkg::TAPS;
    localparam int DIV  = 2 * S * S * S;
    localparam int HALF = DIV / 2;
    localparam int WW   = $clog2(DIV + 1) + 1;
    localparam int PW   = CB + WW;
    localparam int FB   = crs_pkg::FRAC_BITS;
    localparam int NW   = PW + FB + 1;
    localparam int AW   = NW + 1;
    localparam int QB   = crs_pkg::OUT_BITS;
    localparam int RW   = $clog2(DIV) + QB;
    localparam int CW   = (AW > RW + 1) ? AW : RW + 1;

    localparam logic [CW-1:0]        LIMIT = CW'(DIV) << QB;
    localparam logic signed [QB-1:0] MAXV  = {1'b0, {(QB-1){1'b1}}};
    localparam logic signed [QB-1:0] MINV  = {1'b1, {(QB-1){1'b0}}};

    typedef struct packed {
        logic valid;
        logic run_last;
        logic route_done;
    } t_tag;

    logic signed [WW-1:0] w_tab [S][TAPS];
    logic signed [WW-1:0] w_sel [TAPS];
    logic signed [CB-1:0] r_win_x [3];
    logic signed [CB-1:0] r_win_y [3];
    logic signed [CB-1:0] r_new_x;
    logic signed [CB-1:0] r_new_y;
    logic signed [CB-1:0] op_x [TAPS];
    logic signed [CB-1:0] op_y [TAPS];
    logic signed [PW-1:0] r_prod_x [TAPS];
    logic signed [PW-1:0] r_prod_y [TAPS];
    logic signed [NW-1:0] sum_x;
    logic signed [NW-1:0] sum_y;
    logic signed [NW-1:0] r_num_x;
    logic signed [NW-1:0] r_num_y;
    logic                 neg_x;
    logic                 neg_y;
    logic [CW-1:0]        mag_x;
    logic [CW-1:0]        mag_y;
    logic                 ovf_x;
    logic                 ovf_y;
    logic [QB-1:0]        dq_x;
    logic [QB-1:0]        dq_y;
    logic                 dq_neg_x;
    logic                 dq_neg_y;
    logic                 dq_ovf_x;
    logic                 dq_ovf_y;
    logic signed [QB-1:0] sat_x;
    logic signed [QB-1:0] sat_y;
    t_tag                 n_a_tag;
    t_tag                 r_a_tag;
    t_tag                 r_b_tag;
    t_tag                 r_c_tag;
    logic                 adv;
    logic                 r_out_valid;
    logic signed [QB-1:0] r_out_x;
    logic signed [QB-1:0] r_out_y;
    logic                 r_out_run_last;
    logic                 r_out_route_done;

    for (genvar gk = 0; gk < S; gk++) begin : g_wk
        for (genvar gt = 0; gt < TAPS; gt++) begin : g_wt
            assign w_tab[gk][gt] = WW'(crs_pkg::crs_weight(gk, gt, S));
        end
    end

    assign adv = !(r_out_valid && i_stall);

    always_comb begin
        for (int t = 0; t < TAPS; t++) begin
            w_sel[t] = w_tab[i_k][t];
        end
        if (i_cmd.seg_b) begin
            op_x[0] = i_cmd.full_left ? r_win_x[1] : r_win_x[2];
            op_y[0] = i_cmd.full_left ? r_win_y[1] : r_win_y[2];
            op_x[1] = r_win_x[2];
            op_y[1] = r_win_y[2];
            op_x[2] = r_new_x;
            op_y[2] = r_new_y;
        end else begin
            op_x[0] = i_cmd.full_left ? r_win_x[0] : r_win_x[1];
            op_y[0] = i_cmd.full_left ? r_win_y[0] : r_win_y[1];
            op_x[1] = r_win_x[1];
            op_y[1] = r_win_y[1];
            op_x[2] = r_win_x[2];
            op_y[2] = r_win_y[2];
        end
        op_x[3] = r_new_x;
        op_y[3] = r_new_y;
        n_a_tag.valid      = i_cmd.issue;
        n_a_tag.run_last   = i_cmd.run_last;
        n_a_tag.route_done = i_cmd.route_done;
    end

    always_comb begin
        sum_x = NW'(r_prod_x[0]) + NW'(r_prod_x[1]) + NW'(r_prod_x[2]) + NW'(r_prod_x[3]);
        sum_y = NW'(r_prod_y[0]) + NW'(r_prod_y[1]) + NW'(r_prod_y[2]) + NW'(r_prod_y[3]);
        neg_x = r_num_x[NW-1];
        neg_y = r_num_y[NW-1];
        mag_x = neg_x ? (CW'(HALF) - CW'(r_num_x)) : (CW'(r_num_x) + CW'(HALF));
        mag_y = neg_y ? (CW'(HALF) - CW'(r_num_y)) : (CW'(r_num_y) + CW'(HALF));
        ovf_x = mag_x >= LIMIT;
        ovf_y = mag_y >= LIMIT;
    end

    crs_div_pipe #(
        .DIVISOR  (DIV),
        .QUO_BITS (QB),
        .REM_BITS (RW)
    ) u_div_x (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_rem (RW'(mag_x)),
        .i_neg (neg_x),
        .i_ovf (ovf_x),
        .o_quo (dq_x),
        .o_neg (dq_neg_x),
        .o_ovf (dq_ovf_x)
    );

    crs_div_pipe #(
        .DIVISOR  (DIV),
        .QUO_BITS (QB),
        .REM_BITS (RW)
    ) u_div_y (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_rem (RW'(mag_y)),
        .i_neg (neg_y),
        .i_ovf (ovf_y),
        .o_quo (dq_y),
        .o_neg (dq_neg_y),
        .o_ovf (dq_ovf_y)
    );

    always_comb begin
        if (dq_ovf_x || dq_x[QB-1]) begin
            sat_x = dq_neg_x ? MINV : MAXV;
        end else begin
            sat_x = dq_neg_x ? (~dq_x + 1'b1) : dq_x;
        end
        if (dq_ovf_y || dq_y[QB-1]) begin
            sat_y = dq_neg_y ? MINV : MAXV;
        end else begin
            sat_y = dq_neg_y ? (~dq_y + 1'b1) : dq_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_win_x[i] <= '0;
                r_win_y[i] <= '0;
            end
        end else if (i_cmd.update) begin
            if (i_cmd.clear) begin
                for (int i = 0; i < 3; i++) begin
                    r_win_x[i] <= '0;
                    r_win_y[i] <= '0;
                end
            end else begin
                r_win_x[0] <= r_win_x[1];
                r_win_y[0] <= r_win_y[1];
                r_win_x[1] <= r_win_x[2];
                r_win_y[1] <= r_win_y[2];
                r_win_x[2] <= r_new_x;
                r_win_y[2] <= r_new_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag     <= '0;
            r_b_tag     <= '0;
            r_c_tag     <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_a_tag     <= n_a_tag;
            r_b_tag     <= r_a_tag;
            r_c_tag     <= r_b_tag;
            r_out_valid <= r_c_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new_x <= i_point_x;
            r_new_y <= i_point_y;
        end
        if (adv) begin
            for (int t = 0; t < TAPS; t++) begin
                r_prod_x[t] <= PW'(op_x[t]) * PW'(w_sel[t]);
                r_prod_y[t] <= PW'(op_y[t]) * PW'(w_sel[t]);
            end
            r_num_x          <= sum_x <<< FB;
            r_num_y          <= sum_y <<< FB;
            r_out_x          <= sat_x;
            r_out_y          <= sat_y;
            r_out_run_last   <= r_c_tag.run_last;
            r_out_route_done <= r_c_tag.route_done;
        end
    end

    assign o_status.adv = adv;
    assign o_valid      = r_out_valid;
    assign o_sample_x   = r_out_x;
    assign o_sample_y   = r_out_y;
    assign o_run_last   = r_out_run_last;
    assign o_route_done = r_out_route_done;

endmodule

[rtl/crs_ctrl.sv]
// Sequencer that walks the segments of each control point and updates the window.
`include "catmull_rom_curve_sampler_assert.svh"

module crs_ctrl #(
    parameter int SAMPLES_PER_SEGMENT = crs_pkg::SAMPLES_PER_SEGMENT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic                                   i_route_last,
    output logic                                   o_stall,
    input  crs_pkg::t_dp_status                    i_status,
    output crs_pkg::t_dp_cmd                       o_cmd,
    output logic [$clog2(SAMPLES_PER_SEGMENT)-1:0] o_k
);

    localparam int S  = SAMPLES_PER_SEGMENT;
    localparam int KW = $clog2(S);

    localparam logic [KW-1:0] K_LAST   = KW'(S - 1);
    localparam logic [1:0]    SEEN_TWO = 2'd2;
    localparam logic [1:0]    SEEN_MAX = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEG_A,
        ST_SEG_B,
        ST_UPDATE
    } t_state;

    t_state        r_state;
    logic [KW-1:0] r_k;
    logic [1:0]    r_seen;
    logic          r_last;
    logic          accept;
    logic          k_last;
    logic          in_seg;

    assign accept = i_valid && (r_state == ST_IDLE);
    assign o_stall = (r_state != ST_IDLE);
    assign k_last = (r_k == K_LAST);
    assign in_seg = (r_state == ST_SEG_A) || (r_state == ST_SEG_B);

    always_comb begin
        o_cmd.issue      = in_seg && i_status.adv;
        o_cmd.seg_b      = (r_state == ST_SEG_B);
        o_cmd.full_left  = (r_state == ST_SEG_B) ? (r_seen >= SEEN_TWO) : (r_seen == SEEN_MAX);
        o_cmd.run_last   = k_last && ((r_state == ST_SEG_B) || !r_last);
        o_cmd.route_done = o_cmd.run_last && r_last;
        o_cmd.load       = accept;
        o_cmd.update     = (r_state == ST_UPDATE);
        o_cmd.clear      = r_last;
    end

    assign o_k = r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_seen  <= '0;
            r_last  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_last <= i_route_last;
                        if (r_seen >= SEEN_TWO) begin
                            r_state <= ST_SEG_A;
                        end else if (i_route_last && (r_seen != '0)) begin
                            r_state <= ST_SEG_B;
                        end else begin
                            r_state <= ST_UPDATE;
                        end
                    end
                end
                ST_SEG_A: begin
                    if (i_status.adv) begin
                        if (k_last) begin
                            r_k     <= '0;
                            r_state <= r_last ? ST_SEG_B : ST_UPDATE;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                ST_SEG_B: begin
                    if (i_status.adv) begin
                        if (k_last) begin
                            r_k     <= '0;
                            r_state <= ST_UPDATE;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                ST_UPDATE: begin
                    if (r_last) begin
                        r_seen <= '0;
                    end else if (r_seen != SEEN_MAX) begin
                        r_seen <= r_seen + 1'b1;
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `CRS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `CRS_ASSERT_IMPLY(a_k_range, i_clk, i_rst_n, 1'b1, r_k <= K_LAST)
    `CRS_ASSERT_IMPLY(a_k_idle, i_clk, i_rst_n, r_state == ST_IDLE, r_k == '0)
    `CRS_ASSERT_IMPLY(a_seg_b_cause, i_clk, i_rst_n, r_state == ST_SEG_B, r_last && (r_seen != '0))
    `CRS_ASSERT_NEXT(a_route_clear, i_clk, i_rst_n, (r_state == ST_UPDATE) && r_last, r_seen == '0)

endmodule

[rtl/catmull_rom_curve_sampler.sv]
// Top level of the Catmull-Rom curve sampler.
// Control points enter one item at a time; each point that completes a segment yields
// SAMPLES_PER_SEGMENT samples, and a route's final point yields up to two segments.
// The sequencer issues one sample per clock into the blending pipeline while an output
// stall does not hold it, and raises o_stall once a point is accepted, keeping it up until
// the point's segments and window update are done, so a new point is taken only when the
// last one is through. A sample passes the weight multiply, sum, reciprocal-multiply
// rounding divide and output register. An output stall while a sample is held freezes the
// pipeline and holds the sequencer's sample issue.
module catmull_rom_curve_sampler #(
    parameter int SAMPLES_PER_SEGMENT = crs_pkg::SAMPLES_PER_SEGMENT,
    parameter int COORD_BITS          = crs_pkg::COORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_BITS-1:0]        i_point_x,
    input  logic signed [COORD_BITS-1:0]        i_point_y,
    input  logic                                i_route_last,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [crs_pkg::OUT_BITS-1:0] o_sample_x,
    output logic signed [crs_pkg::OUT_BITS-1:0] o_sample_y,
    output logic                                o_run_last,
    output logic                                o_route_done
);

    crs_pkg::t_dp_cmd                       cmd;
    crs_pkg::t_dp_status                    status;
    logic [$clog2(SAMPLES_PER_SEGMENT)-1:0] k;

    crs_ctrl #(
        .SAMPLES_PER_SEGMENT (SAMPLES_PER_SEGMENT)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_route_last (i_route_last),
        .o_stall      (o_stall),
        .i_status     (status),
        .o_cmd        (cmd),
        .o_k          (k)
    );

    crs_datapath #(
        .SAMPLES_PER_SEGMENT (SAMPLES_PER_SEGMENT),
        .COORD_BITS          (COORD_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_cmd        (cmd),
        .i_k          (k),
        .o_status     (status),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample_x   (o_sample_x),
        .o_sample_y   (o_sample_y),
        .o_run_last   (o_run_last),
        .o_route_done (o_route_done)
    );

endmodule
